/* hw/rtl/sdg_pkg.sv */
`default_nettype none
package sdg_pkg;

    localparam int BANK_W = 1;
    localparam int BANK_N = 2 ** BANK_W;
    localparam int DIV_W  = 16;
    localparam int FLAG_W = 8;
    localparam int KIND_W = 4;
    localparam int STAT_W = 2;

    localparam logic [DIV_W-1:0] DIV_RESET = 16'hFFFF;

    localparam logic [KIND_W-1:0] KIND_NOTE_MOD     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_PAT     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SEL_MOD      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SEL_PAT      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CHK_MOD      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CHK_PAT      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CHK_MOD_BANK = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CHK_PAT_BANK = 4'd7;
    localparam logic [KIND_W-1:0] KIND_APPLY        = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_PAYLOAD = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SETTING = 2'd2;

    typedef logic [BANK_W-1:0] bank_t;
    typedef logic [DIV_W-1:0]  div_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } sdg_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/sdg_ctrl.sv */
`default_nettype none
module sdg_ctrl
    import sdg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    output logic      res_valid,
    input  wire logic res_ready,
    output sdg_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic res_valid_reg, res_valid_next;
    logic out_free;

    assign out_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    cmd.execute    = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sdg_dp.sv */
`default_nettype none
module sdg_dp
    import sdg_pkg::*;
#(
    parameter int BANK_COUNT              = 2,
    parameter int DEFAULT_STEPS_INTENSITY = 10,
    parameter int DEFAULT_STEPS_PHASE     = 40,
    parameter int FIXED_RATE_BIT          = 0,
    parameter int STRICT_BIT              = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sdg_cmd_t          cmd,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [BANK_W-1:0] bank,
    input  wire logic [DIV_W-1:0]  divider,
    input  wire logic [FLAG_W-1:0] flag,
    input  wire logic [DIV_W-1:0]  rate_intensity_in,
    input  wire logic [DIV_W-1:0]  rate_phase_in,
    input  wire logic [DIV_W-1:0]  steps_intensity_in,
    input  wire logic [DIV_W-1:0]  steps_phase_in,
    output logic [STAT_W-1:0]      status,
    output logic                   violates,
    output logic                   apply,
    output logic [DIV_W-1:0]       rate_intensity_out,
    output logic [DIV_W-1:0]       rate_phase_out,
    output logic [DIV_W-1:0]       steps_intensity_out,
    output logic [DIV_W-1:0]       steps_phase_out,
    output logic [FLAG_W-1:0]      flag_out
);

    // captured command
    logic [KIND_W-1:0] kind_reg;
    bank_t             bank_reg;
    div_t              div_reg;
    logic [FLAG_W-1:0] flag_reg;
    div_t              ri_reg, rp_reg, si_reg, sp_reg;

    // guard state
    logic  strict_reg, strict_next;
    div_t  dsi_reg, dsi_next;
    div_t  dsp_reg, dsp_next;
    div_t  mod_div_reg [BANK_N];
    div_t  pat_div_reg [BANK_N];
    bank_t act_mod_reg, act_pat_reg;

    // result
    logic [STAT_W-1:0] status_reg, status_next;
    logic              viol_reg, viol_next;
    logic              apply_reg, apply_next;
    div_t              ri_out_reg, rp_out_reg, si_out_reg, sp_out_reg;
    logic [FLAG_W-1:0] flag_out_reg;

    logic bank_ok;
    logic fixed, strict_req;
    div_t md, pd, chk_mod, chk_pat;
    logic mod_v, pat_v;
    logic wr_mod, wr_pat, sel_mod, sel_pat;

    assign bank_ok    = (int'(bank_reg) < BANK_COUNT);
    assign fixed      = flag_reg[FIXED_RATE_BIT];
    assign strict_req = flag_reg[STRICT_BIT];
    assign md         = mod_div_reg[act_mod_reg];
    assign pd         = pat_div_reg[act_pat_reg];

    // direct checks use the divider field, bank checks the stored one
    assign chk_mod = (kind_reg == KIND_CHK_MOD) ? div_reg : mod_div_reg[bank_reg];
    assign chk_pat = (kind_reg == KIND_CHK_PAT) ? div_reg : pat_div_reg[bank_reg];
    assign mod_v   = strict_reg && (chk_mod < dsi_reg);
    assign pat_v   = strict_reg && ((chk_pat < dsi_reg) || (chk_pat < dsp_reg));

    always_comb
    begin
        status_next = ST_OK;
        viol_next   = 1'b0;
        apply_next  = 1'b0;
        strict_next = strict_reg;
        dsi_next    = dsi_reg;
        dsp_next    = dsp_reg;
        wr_mod      = 1'b0;
        wr_pat      = 1'b0;
        sel_mod     = 1'b0;
        sel_pat     = 1'b0;
        case (kind_reg)
            KIND_NOTE_MOD:     wr_mod  = bank_ok;
            KIND_NOTE_PAT:     wr_pat  = bank_ok;
            KIND_SEL_MOD:      sel_mod = bank_ok;
            KIND_SEL_PAT:      sel_pat = bank_ok;
            KIND_CHK_MOD:      viol_next = mod_v;
            KIND_CHK_PAT:      viol_next = pat_v;
            KIND_CHK_MOD_BANK: viol_next = bank_ok && mod_v;
            KIND_CHK_PAT_BANK: viol_next = bank_ok && pat_v;
            KIND_APPLY:
            begin
                if (fixed)
                begin
                    // fixed update rate keeps the stored steps
                    if (ri_reg == '0 || rp_reg == '0)
                    begin
                        status_next = ST_BAD_PAYLOAD;
                    end
                    else
                    begin
                        strict_next = 1'b0;
                        apply_next  = 1'b1;
                    end
                end
                else if (si_reg == '0 || sp_reg == '0)
                begin
                    status_next = ST_BAD_PAYLOAD;
                end
                else if (strict_req && (md < si_reg || pd < si_reg || pd < sp_reg))
                begin
                    status_next = ST_BAD_SETTING;
                end
                else
                begin
                    strict_next = strict_req;
                    dsi_next    = si_reg;
                    dsp_next    = sp_reg;
                    apply_next  = 1'b1;
                end
            end
            default:           status_next = ST_BAD_PAYLOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            bank_reg <= bank;
            div_reg  <= divider;
            flag_reg <= flag;
            ri_reg   <= rate_intensity_in;
            rp_reg   <= rate_phase_in;
            si_reg   <= steps_intensity_in;
            sp_reg   <= steps_phase_in;
        end
        if (cmd.execute)
        begin
            status_reg   <= status_next;
            viol_reg     <= viol_next;
            apply_reg    <= apply_next;
            ri_out_reg   <= apply_next ? ri_reg : '0;
            rp_out_reg   <= apply_next ? rp_reg : '0;
            si_out_reg   <= apply_next ? si_reg : '0;
            sp_out_reg   <= apply_next ? sp_reg : '0;
            flag_out_reg <= apply_next ? flag_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg  <= 1'b0;
            dsi_reg     <= DIV_W'(DEFAULT_STEPS_INTENSITY);
            dsp_reg     <= DIV_W'(DEFAULT_STEPS_PHASE);
            act_mod_reg <= '0;
            act_pat_reg <= '0;
            for (int i = 0; i < BANK_N; i++)
            begin
                mod_div_reg[i] <= DIV_RESET;
                pat_div_reg[i] <= DIV_RESET;
            end
        end
        else if (cmd.execute)
        begin
            strict_reg <= strict_next;
            dsi_reg    <= dsi_next;
            dsp_reg    <= dsp_next;
            if (sel_mod)
            begin
                act_mod_reg <= bank_reg;
            end
            if (sel_pat)
            begin
                act_pat_reg <= bank_reg;
            end
            if (wr_mod)
            begin
                mod_div_reg[bank_reg] <= div_reg;
            end
            if (wr_pat)
            begin
                pat_div_reg[bank_reg] <= div_reg;
            end
        end
    end

    assign status              = status_reg;
    assign violates            = viol_reg;
    assign apply               = apply_reg;
    assign rate_intensity_out  = ri_out_reg;
    assign rate_phase_out      = rp_out_reg;
    assign steps_intensity_out = si_out_reg;
    assign steps_phase_out     = sp_out_reg;
    assign flag_out            = flag_out_reg;

endmodule
`default_nettype wire

/* hw/rtl/silencer_divider_guard_top.sv */
// Silencer divider guard: one result per command on the res channel, in order.
// Each command is first registered, then evaluated against the stored dividers
// and steps and loaded into the output register once that register is free.
// The next command is taken while a result still waits in the output register,
// but the two-state controller takes none while one is still being evaluated.
// Reset loads the default completion steps and sets every divider to 0xFFFF;
// no clearing pass is needed.
`default_nettype none
module silencer_divider_guard_top
    import sdg_pkg::*;
#(
    parameter int BANK_COUNT              = 2,
    parameter int DEFAULT_STEPS_INTENSITY = 10,
    parameter int DEFAULT_STEPS_PHASE     = 40,
    parameter int FIXED_RATE_BIT          = 0,
    parameter int STRICT_BIT              = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [BANK_W-1:0] bank,
    input  wire logic [DIV_W-1:0]  divider,
    input  wire logic [FLAG_W-1:0] flag,
    input  wire logic [DIV_W-1:0]  rate_intensity_in,
    input  wire logic [DIV_W-1:0]  rate_phase_in,
    input  wire logic [DIV_W-1:0]  steps_intensity_in,
    input  wire logic [DIV_W-1:0]  steps_phase_in,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [STAT_W-1:0]      status,
    output logic                   violates,
    output logic                   apply,
    output logic [DIV_W-1:0]       rate_intensity_out,
    output logic [DIV_W-1:0]       rate_phase_out,
    output logic [DIV_W-1:0]       steps_intensity_out,
    output logic [DIV_W-1:0]       steps_phase_out,
    output logic [FLAG_W-1:0]      flag_out
);

    sdg_cmd_t cmd;

    sdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd)
    );

    sdg_dp #(
        .BANK_COUNT              (BANK_COUNT),
        .DEFAULT_STEPS_INTENSITY (DEFAULT_STEPS_INTENSITY),
        .DEFAULT_STEPS_PHASE     (DEFAULT_STEPS_PHASE),
        .FIXED_RATE_BIT          (FIXED_RATE_BIT),
        .STRICT_BIT              (STRICT_BIT)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .kind                (kind),
        .bank                (bank),
        .divider             (divider),
        .flag                (flag),
        .rate_intensity_in   (rate_intensity_in),
        .rate_phase_in       (rate_phase_in),
        .steps_intensity_in  (steps_intensity_in),
        .steps_phase_in      (steps_phase_in),
        .status              (status),
        .violates            (violates),
        .apply               (apply),
        .rate_intensity_out  (rate_intensity_out),
        .rate_phase_out      (rate_phase_out),
        .steps_intensity_out (steps_intensity_out),
        .steps_phase_out     (steps_phase_out),
        .flag_out            (flag_out)
    );

endmodule
`default_nettype wire

/* hw/rtl/sdg_checker.sv */
`default_nettype none
module sdg_checker
    import sdg_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [STAT_W-1:0] status,
    input wire logic              violates,
    input wire logic              apply,
    input wire logic [DIV_W-1:0]  rate_intensity_out,
    input wire logic [DIV_W-1:0]  rate_phase_out,
    input wire logic [DIV_W-1:0]  steps_intensity_out,
    input wire logic [DIV_W-1:0]  steps_phase_out,
    input wire logic [FLAG_W-1:0] flag_out
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(apply))
        else $error("result changed while stalled");

    // a command is evaluated before the next one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in flight");

    // an apply strobe only comes with ok status and no violation
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && apply |-> status == ST_OK && !violates)
        else $error("apply with bad status");

    // forwarded values are zero without apply
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !apply |-> rate_intensity_out == '0 && rate_phase_out == '0 &&
            steps_intensity_out == '0 && steps_phase_out == '0 && flag_out == '0)
        else $error("forwarded values without apply");

    // a violation is only reported on an ok check
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && violates |-> status == ST_OK)
        else $error("violation with error status");

endmodule

bind silencer_divider_guard_top sdg_checker u_sdg_checker (.*);
`default_nettype wire

/* sim/silencer_divider_guard_top_test.sv */
`timescale 1ns / 1ps
module silencer_divider_guard_top_test;
    import sdg_pkg::*;

    localparam int GUARD_BANKS     = 2;
    localparam int STEPS_INT_RESET = 10;
    localparam int STEPS_PH_RESET  = 40;
    localparam int FIXED_BIT       = 0;
    localparam int STRICT_POS      = 1;
    localparam int CMD_TOTAL       = 550;

    localparam logic [FLAG_W-1:0] FLAG_FIXED  = 8'(1) << FIXED_BIT;
    localparam logic [FLAG_W-1:0] FLAG_STRICT = 8'(1) << STRICT_POS;
    localparam logic [FLAG_W-1:0] FLAG_ALL    = 8'hFF;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        bank_t             bank;
        div_t              divider;
        logic [FLAG_W-1:0] flag;
        div_t              rate_int;
        div_t              rate_ph;
        div_t              steps_int;
        div_t              steps_ph;
    } guard_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              violates;
        logic              apply;
        div_t              rate_int;
        div_t              rate_ph;
        div_t              steps_int;
        div_t              steps_ph;
        logic [FLAG_W-1:0] flag;
    } guard_res_t;

    typedef struct {
        guard_cmd_t cmd;
        bit         typed;
        guard_res_t res;
    } dir_row_t;

    localparam guard_res_t RES_QUIET = '0;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [KIND_W-1:0] kind;
    logic [BANK_W-1:0] bank;
    logic [DIV_W-1:0]  divider;
    logic [FLAG_W-1:0] flag;
    logic [DIV_W-1:0]  rate_intensity_in;
    logic [DIV_W-1:0]  rate_phase_in;
    logic [DIV_W-1:0]  steps_intensity_in;
    logic [DIV_W-1:0]  steps_phase_in;
    logic              res_valid;
    logic              res_ready;
    logic [STAT_W-1:0] status;
    logic              violates;
    logic              apply;
    logic [DIV_W-1:0]  rate_intensity_out;
    logic [DIV_W-1:0]  rate_phase_out;
    logic [DIV_W-1:0]  steps_intensity_out;
    logic [DIV_W-1:0]  steps_phase_out;
    logic [FLAG_W-1:0] flag_out;

    // guard state as seen by the predictor
    logic  strict_q;
    div_t  steps_int_q;
    div_t  steps_ph_q;
    div_t  mod_div_q [GUARD_BANKS];
    div_t  pat_div_q [GUARD_BANKS];
    bank_t mod_sel_q;
    bank_t pat_sel_q;

    guard_res_t expected_q[$];
    dir_row_t   dir_tab[$];
    int         errors;
    int         cmd_sent;
    bit         tx_idle;
    bit         rx_idle;

    silencer_divider_guard_top #(
        .BANK_COUNT              (GUARD_BANKS),
        .DEFAULT_STEPS_INTENSITY (STEPS_INT_RESET),
        .DEFAULT_STEPS_PHASE     (STEPS_PH_RESET),
        .FIXED_RATE_BIT          (FIXED_BIT),
        .STRICT_BIT              (STRICT_POS)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd_valid           (cmd_valid),
        .cmd_ready           (cmd_ready),
        .kind                (kind),
        .bank                (bank),
        .divider             (divider),
        .flag                (flag),
        .rate_intensity_in   (rate_intensity_in),
        .rate_phase_in       (rate_phase_in),
        .steps_intensity_in  (steps_intensity_in),
        .steps_phase_in      (steps_phase_in),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .status              (status),
        .violates            (violates),
        .apply               (apply),
        .rate_intensity_out  (rate_intensity_out),
        .rate_phase_out      (rate_phase_out),
        .steps_intensity_out (steps_intensity_out),
        .steps_phase_out     (steps_phase_out),
        .flag_out            (flag_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic mod_too_fast(div_t d);
        return strict_q && (d < steps_int_q);
    endfunction

    function automatic logic pat_too_fast(div_t d);
        return strict_q && (d < steps_int_q || d < steps_ph_q);
    endfunction

    function automatic guard_res_t predict_guard(guard_cmd_t c);
        guard_res_t r;
        logic       bank_ok;
        div_t       md;
        div_t       pd;
        r       = '0;
        bank_ok = c.bank < GUARD_BANKS;
        md      = mod_div_q[mod_sel_q];
        pd      = pat_div_q[pat_sel_q];
        case (c.kind)
            KIND_NOTE_MOD:     if (bank_ok) mod_div_q[c.bank] = c.divider;
            KIND_NOTE_PAT:     if (bank_ok) pat_div_q[c.bank] = c.divider;
            KIND_SEL_MOD:      if (bank_ok) mod_sel_q = c.bank;
            KIND_SEL_PAT:      if (bank_ok) pat_sel_q = c.bank;
            KIND_CHK_MOD:      r.violates = mod_too_fast(c.divider);
            KIND_CHK_PAT:      r.violates = pat_too_fast(c.divider);
            KIND_CHK_MOD_BANK: if (bank_ok) r.violates = mod_too_fast(mod_div_q[c.bank]);
            KIND_CHK_PAT_BANK: if (bank_ok) r.violates = pat_too_fast(pat_div_q[c.bank]);
            KIND_APPLY:
            begin
                if (c.flag[FIXED_BIT])
                begin
                    // fixed rate keeps the stored steps
                    if (c.rate_int == '0 || c.rate_ph == '0)
                        r.status = ST_BAD_PAYLOAD;
                    else
                        strict_q = 1'b0;
                end
                else if (c.steps_int == '0 || c.steps_ph == '0)
                    r.status = ST_BAD_PAYLOAD;
                else if (c.flag[STRICT_POS] &&
                         (md < c.steps_int || pd < c.steps_int || pd < c.steps_ph))
                    r.status = ST_BAD_SETTING;
                else
                begin
                    strict_q    = c.flag[STRICT_POS];
                    steps_int_q = c.steps_int;
                    steps_ph_q  = c.steps_ph;
                end
                if (r.status == ST_OK)
                begin
                    r.apply     = 1'b1;
                    r.rate_int  = c.rate_int;
                    r.rate_ph   = c.rate_ph;
                    r.steps_int = c.steps_int;
                    r.steps_ph  = c.steps_ph;
                    r.flag      = c.flag;
                end
            end
            default: r.status = ST_BAD_PAYLOAD;
        endcase
        return r;
    endfunction

    function automatic guard_cmd_t mk_cmd(logic [KIND_W-1:0] k, int b, int d, int f,
                                          int ri, int rp, int si, int sp);
        guard_cmd_t c;
        c.kind      = k;
        c.bank      = bank_t'(b);
        c.divider   = div_t'(d);
        c.flag      = FLAG_W'(f);
        c.rate_int  = div_t'(ri);
        c.rate_ph   = div_t'(rp);
        c.steps_int = div_t'(si);
        c.steps_ph  = div_t'(sp);
        return c;
    endfunction

    function automatic guard_res_t mk_res(logic [STAT_W-1:0] st, bit v, bit a,
                                          int ri, int rp, int si, int sp, int f);
        guard_res_t r;
        r.status    = st;
        r.violates  = v;
        r.apply     = a;
        r.rate_int  = div_t'(ri);
        r.rate_ph   = div_t'(rp);
        r.steps_int = div_t'(si);
        r.steps_ph  = div_t'(sp);
        r.flag      = FLAG_W'(f);
        return r;
    endfunction

    function automatic div_t pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DIV_RESET;
            2, 3:    return div_t'($urandom_range(0, 64));
            default: return div_t'($urandom);
        endcase
    endfunction

    function automatic guard_cmd_t rand_cmd();
        guard_cmd_t c;
        c.kind = KIND_W'($urandom_range(KIND_NOTE_MOD, KIND_APPLY));
        if ($urandom_range(0, 15) == 0)
            c.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        c.bank      = bank_t'($urandom);
        c.divider   = pick_word();
        c.flag      = FLAG_W'($urandom);
        if ($urandom_range(0, 1) != 0)
            c.flag[FIXED_BIT] = 1'b0;
        c.rate_int  = pick_word();
        c.rate_ph   = pick_word();
        c.steps_int = pick_word();
        c.steps_ph  = pick_word();
        return c;
    endfunction

    task automatic send_cmd(guard_cmd_t c, bit typed, guard_res_t want);
        int         gap;
        guard_res_t pred;
        if ($urandom_range(0, 39) == 0)
            tx_idle = !tx_idle;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind               <= c.kind;
        bank               <= c.bank;
        divider            <= c.divider;
        flag               <= c.flag;
        rate_intensity_in  <= c.rate_int;
        rate_phase_in      <= c.rate_ph;
        steps_intensity_in <= c.steps_int;
        steps_phase_in     <= c.steps_ph;
        cmd_valid          <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pred = predict_guard(c);
        expected_q.push_back(typed ? want : pred);
        cmd_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
    endtask

    // record dividers, select their banks, apply a setting near them, then check
    task automatic send_program();
        guard_cmd_t c;
        bank_t      b;
        div_t       dm;
        div_t       dp;
        div_t       lim;
        b  = bank_t'($urandom);
        dm = pick_word();
        dp = pick_word();
        c = rand_cmd(); c.kind = KIND_NOTE_MOD; c.bank = b; c.divider = dm;
        send_cmd(c, 1'b0, RES_QUIET);
        c = rand_cmd(); c.kind = KIND_NOTE_PAT; c.bank = b; c.divider = dp;
        send_cmd(c, 1'b0, RES_QUIET);
        c = rand_cmd(); c.kind = KIND_SEL_MOD; c.bank = b;
        send_cmd(c, 1'b0, RES_QUIET);
        c = rand_cmd(); c.kind = KIND_SEL_PAT; c.bank = b;
        send_cmd(c, 1'b0, RES_QUIET);
        lim = (dm < dp) ? dm : dp;
        c = rand_cmd(); c.kind = KIND_APPLY;
        if ($urandom_range(0, 3) != 0)
        begin
            c.flag[FIXED_BIT]  = 1'b0;
            c.flag[STRICT_POS] = 1'b1;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            c.steps_int = div_t'($urandom_range(0, lim));
            c.steps_ph  = div_t'($urandom_range(0, lim));
        end
        send_cmd(c, 1'b0, RES_QUIET);
        repeat (2)
        begin
            c = rand_cmd();
            c.kind = ($urandom_range(0, 1) != 0) ? KIND_CHK_MOD_BANK : KIND_CHK_PAT_BANK;
            send_cmd(c, 1'b0, RES_QUIET);
        end
        c = rand_cmd();
        c.kind = ($urandom_range(0, 1) != 0) ? KIND_CHK_MOD : KIND_CHK_PAT;
        send_cmd(c, 1'b0, RES_QUIET);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: random stalls, compares every transfer against the oldest expectation
    initial
    begin
        int         stall;
        guard_res_t got;
        guard_res_t want;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_idle = !rx_idle;
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (stall != 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            got = {status, violates, apply, rate_intensity_out, rate_phase_out,
                   steps_intensity_out, steps_phase_out, flag_out};
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %0h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("violates", want.violates, got.violates);
                check_field("apply", want.apply, got.apply);
                check_field("rate_intensity_out", want.rate_int, got.rate_int);
                check_field("rate_phase_out", want.rate_ph, got.rate_ph);
                check_field("steps_intensity_out", want.steps_int, got.steps_int);
                check_field("steps_phase_out", want.steps_ph, got.steps_ph);
                check_field("flag_out", want.flag, got.flag);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        bit mid_drained;
        rst_n              = 1'b0;
        cmd_valid          = 1'b0;
        kind               = '0;
        bank               = '0;
        divider            = '0;
        flag               = '0;
        rate_intensity_in  = '0;
        rate_phase_in      = '0;
        steps_intensity_in = '0;
        steps_phase_in     = '0;
        errors             = 0;
        cmd_sent           = 0;
        tx_idle            = 1'b1;
        rx_idle            = 1'b1;
        mid_drained        = 1'b0;

        strict_q    = 1'b0;
        steps_int_q = div_t'(STEPS_INT_RESET);
        steps_ph_q  = div_t'(STEPS_PH_RESET);
        for (int i = 0; i < GUARD_BANKS; i++)
        begin
            mod_div_q[i] = DIV_RESET;
            pat_div_q[i] = DIV_RESET;
        end
        mod_sel_q = '0;
        pat_sel_q = '0;

        // after reset, unused kinds, zero rates and steps
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_MOD_BANK, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_PAT, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_UNUSED_HI, 1, DIV_RESET, FLAG_ALL,
                                            DIV_RESET, DIV_RESET, DIV_RESET, DIV_RESET),
                                     1'b1, mk_res(ST_BAD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, mk_res(ST_BAD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, FLAG_FIXED, 0, 5, 1, 1),
                                     1'b1, mk_res(ST_BAD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, FLAG_FIXED, 5, 0, 1, 1),
                                     1'b1, mk_res(ST_BAD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, 0, 7, 7, 0, 3),
                                     1'b1, mk_res(ST_BAD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, FLAG_STRICT, 7, 7, 3, 0),
                                     1'b1, mk_res(ST_BAD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0)});
        // strict setting, then checks on both sides of the step counts
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, FLAG_STRICT, 100, 200, 10, 40),
                                     1'b1, mk_res(ST_OK, 0, 1, 100, 200, 10, 40, FLAG_STRICT)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_MOD, 0, 9, 0, 0, 0, 0, 0),
                                     1'b1, mk_res(ST_OK, 1, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_MOD, 0, 10, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_PAT, 0, 39, 0, 0, 0, 0, 0),
                                     1'b1, mk_res(ST_OK, 1, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_PAT, 0, 40, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_NOTE_MOD, 1, 0, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_SEL_MOD, 1, 0, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_MOD_BANK, 1, 0, 0, 0, 0, 0, 0),
                                     1'b1, mk_res(ST_OK, 1, 0, 0, 0, 0, 0, 0)});
        // active mod divider of zero rejects any strict setting
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, FLAG_STRICT, 1, 1, 1, 1),
                                     1'b1, mk_res(ST_BAD_SETTING, 0, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_MOD, 0, DIV_RESET, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_NOTE_PAT, 1, 5, 0, 0, 0, 0, 0),
                                     1'b0, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_SEL_PAT, 1, 0, 0, 0, 0, 0, 0),
                                     1'b0, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_PAT_BANK, 1, 0, 0, 0, 0, 0, 0),
                                     1'b0, RES_QUIET});
        // all-ones flag means fixed rate: strict drops, steps stay
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 1, DIV_RESET, FLAG_ALL, DIV_RESET,
                                            DIV_RESET, DIV_RESET, DIV_RESET),
                                     1'b1, mk_res(ST_OK, 0, 1, DIV_RESET, DIV_RESET,
                                                  DIV_RESET, DIV_RESET, FLAG_ALL)});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_CHK_PAT_BANK, 1, 0, 0, 0, 0, 0, 0),
                                     1'b1, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_NOTE_MOD, 1, DIV_RESET, 0, 0, 0, 0, 0),
                                     1'b0, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, FLAG_STRICT, 3, 4, 5, 5),
                                     1'b0, RES_QUIET});
        dir_tab.push_back(dir_row_t'{mk_cmd(KIND_APPLY, 0, 0, 0, 0, 0, DIV_RESET, DIV_RESET),
                                     1'b1, mk_res(ST_OK, 0, 1, 0, 0, DIV_RESET, DIV_RESET, 0)});

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
        drain_results();

        while (cmd_sent < CMD_TOTAL)
        begin
            if (!mid_drained && cmd_sent >= 300)
            begin
                drain_results();
                mid_drained = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
                send_program();
            else
                send_cmd(rand_cmd(), 1'b0, RES_QUIET);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
